### sv/nnt_pkg.sv
// ----------------------------------------------------------------------------
// nnt_pkg: shared types and constants for the nearest-neighbor tour block
// Sizes, controller state encoding and controller/datapath signal groups.
// ----------------------------------------------------------------------------
package nnt_pkg;

  localparam int MAX_CITIES = 32;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int CNT_W      = $clog2(MAX_CITIES + 1);
  localparam int COORD_W    = 16;
  localparam int ABS_W      = COORD_W;
  localparam int SQ_W       = 2 * ABS_W;
  localparam int DIST_W     = SQ_W + 1;
  localparam int CITY_W     = 6;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FIRST,
    ST_CHECK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT,
    ST_CLOSE
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic store;       // accept one city item
    logic first;       // emit city 0 and start the tour
    logic scan_clear;  // restart the scan over stored cities
    logic scan_issue;  // read the next city into the distance pipeline
    logic emit_best;   // move to the nearest city and emit it
    logic close;       // emit the return to city 0 and clear the set
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic step_more;   // tour positions still to fill
    logic scan_last;   // scan index is on the last stored city
    logic pipe_busy;   // distance pipeline still holds items
    logic out_busy;    // result register cannot take a new item
  } status_t;

endpackage

### sv/nnt_in_if.sv
// ----------------------------------------------------------------------------
// nnt_in_if: city input channel
// valid/ready handshake carrying one city's coordinates and the last flag.
// ----------------------------------------------------------------------------
interface nnt_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] city_x;
  logic signed [15:0] city_y;
  logic               last_city;

  modport source (output valid, output city_x, output city_y, output last_city,
                  input ready);
  modport sink   (input valid, input city_x, input city_y, input last_city,
                  output ready);
endinterface

### sv/nnt_out_if.sv
// ----------------------------------------------------------------------------
// nnt_out_if: tour output channel
// valid/ready handshake carrying one tour position.
// ----------------------------------------------------------------------------
interface nnt_out_if;
  logic       valid;
  logic       ready;
  logic [5:0] tour_city;
  logic       tour_end;

  modport source (output valid, output tour_city, output tour_end, input ready);
  modport sink   (input valid, input tour_city, input tour_end, output ready);
endinterface

### sv/nnt_datapath.sv
// ----------------------------------------------------------------------------
// nnt_datapath: city store, distance pipeline and tour bookkeeping
// Coordinate memories, a three-stage squared-distance pipeline, the running
// minimum, the visited mask and the result register.
// ----------------------------------------------------------------------------
module nnt_datapath
  import nnt_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic signed [COORD_W-1:0] in_x,
  input  logic signed [COORD_W-1:0] in_y,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [CITY_W-1:0]         out_city,
  output logic                      out_end
);

  // Coordinate memories
  logic signed [COORD_W-1:0] x_mem [MAX_CITIES];
  logic signed [COORD_W-1:0] y_mem [MAX_CITIES];

  logic [CNT_W-1:0]          city_count;
  logic [CNT_W-1:0]          step;
  logic [MAX_CITIES-1:0]     visited;
  logic signed [COORD_W-1:0] first_x, first_y;
  logic signed [COORD_W-1:0] cur_x, cur_y;
  logic [IDX_W-1:0]          scan_i;

  // Pipeline stage registers
  logic                      v1, v2, v3;
  logic [IDX_W-1:0]          idx1, idx2, idx3;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [COORD_W-1:0] x2, y2, x3, y3;
  logic                      vis2, vis3;
  logic [ABS_W-1:0]          ax, ay;
  logic [SQ_W-1:0]           sqx, sqy;

  // Running minimum
  logic                      found;
  logic [DIST_W-1:0]         best_d;
  logic [IDX_W-1:0]          best;
  logic signed [COORD_W-1:0] best_x, best_y;

  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic [DIST_W-1:0]         cand_d;
  logic                      take;

  // Store write
  always_ff @(posedge clk) begin
    if (cmd.store && city_count < CNT_W'(MAX_CITIES)) begin
      x_mem[city_count[IDX_W-1:0]] <= in_x;
      y_mem[city_count[IDX_W-1:0]] <= in_y;
    end
  end

  // Store read, registered
  always_ff @(posedge clk) begin
    if (cmd.scan_issue) begin
      rd_x <= x_mem[scan_i];
      rd_y <= y_mem[scan_i];
    end
  end

  // City count and first city coordinates
  always_ff @(posedge clk) begin
    if (rst) begin
      city_count <= '0;
    end else if (cmd.close) begin
      city_count <= '0;
    end else if (cmd.store && city_count < CNT_W'(MAX_CITIES)) begin
      city_count <= city_count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store && city_count == '0) begin
      first_x <= in_x;
      first_y <= in_y;
    end
  end

  // Absolute coordinate differences against the current city
  always_comb begin
    dx  = {rd_x[COORD_W-1], rd_x} - {cur_x[COORD_W-1], cur_x};
    dy  = {rd_y[COORD_W-1], rd_y} - {cur_y[COORD_W-1], cur_y};
    adx = dx[COORD_W] ? (COORD_W+1)'(1) + (COORD_W+1)'(~dx) : (COORD_W+1)'(dx);
    ady = dy[COORD_W] ? (COORD_W+1)'(1) + (COORD_W+1)'(~dy) : (COORD_W+1)'(dy);
  end

  assign cand_d = {1'b0, sqx} + {1'b0, sqy};
  assign take   = v3 && !vis3 && (!found || cand_d < best_d);

  // Distance pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= cmd.scan_issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_issue) idx1 <= scan_i;
    idx2 <= idx1;
    vis2 <= visited[idx1];
    x2   <= rd_x;
    y2   <= rd_y;
    ax   <= adx[ABS_W-1:0];
    ay   <= ady[ABS_W-1:0];
    idx3 <= idx2;
    vis3 <= vis2;
    x3   <= x2;
    y3   <= y2;
    sqx  <= ax * ax;
    sqy  <= ay * ay;
  end

  // Scan index
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_i <= '0;
    end else if (cmd.scan_issue) begin
      scan_i <= scan_i + IDX_W'(1);
    end
  end

  // Running minimum, lowest index wins ties since scan is in order
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.scan_clear) begin
      found <= 1'b0;
    end else if (take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_d <= cand_d;
      best   <= idx3;
      best_x <= x3;
      best_y <= y3;
    end
  end

  // Tour bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      visited <= '0;
      step    <= '0;
    end else if (cmd.first) begin
      visited    <= MAX_CITIES'(1);
      step       <= CNT_W'(1);
    end else if (cmd.emit_best) begin
      visited[best] <= 1'b1;
      step          <= step + CNT_W'(1);
    end else if (cmd.close) begin
      visited <= '0;
      step    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first) begin
      cur_x <= first_x;
      cur_y <= first_y;
    end else if (cmd.emit_best) begin
      cur_x <= best_x;
      cur_y <= best_y;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.first || cmd.emit_best || cmd.close) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.first || cmd.close) begin
      out_city <= '0;
      out_end  <= cmd.close;
    end else if (cmd.emit_best) begin
      out_city <= CITY_W'(best);
      out_end  <= 1'b0;
    end
  end

  // Status
  always_comb begin
    status.step_more = step < city_count;
    status.scan_last = {1'b0, scan_i} == CNT_W'(city_count - CNT_W'(1));
    status.pipe_busy = v1 || v2 || v3;
    status.out_busy  = out_valid && !out_ready;
  end

endmodule

### sv/nnt_ctrl.sv
// ----------------------------------------------------------------------------
// nnt_ctrl: tour sequencer
// Loads cities, then walks the tour: scan, drain, emit, and finally close.
// ----------------------------------------------------------------------------
module nnt_ctrl
  import nnt_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    in_last,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_LOAD: begin
        in_ready  = 1'b1;
        cmd.store = in_valid;
        if (in_valid && in_last) state_next = ST_FIRST;
      end
      ST_FIRST: begin
        if (!status.out_busy) begin
          cmd.first  = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        cmd.scan_clear = 1'b1;
        state_next     = status.step_more ? ST_SCAN : ST_CLOSE;
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (status.scan_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!status.out_busy) begin
          cmd.emit_best = 1'b1;
          state_next    = ST_CHECK;
        end
      end
      ST_CLOSE: begin
        if (!status.out_busy) begin
          cmd.close  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      default: state_next = ST_LOAD;
    endcase
  end

endmodule

### sv/nearest_neighbor_tour_top.sv
// ----------------------------------------------------------------------------
// nearest_neighbor_tour_top: greedy nearest-neighbor tour builder
// Stores up to MAX_CITIES cities and emits a nearest-neighbor tour from city 0.
// ----------------------------------------------------------------------------
// Each city item is written to the coordinate store as it is taken;
// cities beyond MAX_CITIES are dropped. The item flagged last_city starts the
// tour: city 0 is emitted first, then each further step scans all N stored
// cities through the single read port of the coordinate store and a
// three-stage squared-distance pipeline, and emits the nearest unvisited
// city once the pipeline has drained and the output can take it. The tour
// ends with a return to city 0 flagged tour_end; new cities are taken again
// while that final item waits on the output.
module nearest_neighbor_tour_top
  import nnt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  nnt_in_if.sink           city_in,
  nnt_out_if.source        tour_out
);

  cmd_t    cmd;
  status_t status;

  nnt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (city_in.valid),
    .in_last  (city_in.last_city),
    .in_ready (city_in.ready),
    .status   (status),
    .cmd      (cmd)
  );

  nnt_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .in_x      (city_in.city_x),
    .in_y      (city_in.city_y),
    .out_valid (tour_out.valid),
    .out_ready (tour_out.ready),
    .out_city  (tour_out.tour_city),
    .out_end   (tour_out.tour_end)
  );

endmodule
